FILE: hw/rtl/acc_cpu_pkg.sv
package acc_cpu_pkg;

  localparam int unsigned MemWordsDefault = 65536;
  localparam logic [16:0] ProtLimitReset = 17'd512;

  localparam logic [15:0] AddrDisplay = 16'hFFF0;
  localparam logic [15:0] AddrStatus  = 16'hFFF1;
  localparam logic [15:0] AddrIo2     = 16'hFFF2;
  localparam logic [15:0] AddrIo3     = 16'hFFF3;
  localparam logic [15:0] AddrKeyb    = 16'hFFFF;

  typedef enum logic [2:0] {
    FAULT_NONE    = 3'd0,
    FAULT_OPCODE  = 3'd1,
    FAULT_MODE    = 3'd2,
    FAULT_REG     = 3'd3,
    FAULT_DIVZERO = 3'd4,
    FAULT_PROTECT = 3'd5,
    FAULT_NULL    = 3'd6
  } fault_t;

  typedef enum logic [7:0] {
    OP_ST = 8'd0, OP_LD = 8'd1, OP_LDI = 8'd2, OP_ADD = 8'd3, OP_SUB = 8'd4,
    OP_MUL = 8'd5, OP_DIV = 8'd6, OP_MOD = 8'd7, OP_AND = 8'd8, OP_OR = 8'd9,
    OP_XOR = 8'd10, OP_NOT = 8'd11, OP_JMP = 8'd12, OP_JZ = 8'd13,
    OP_JN = 8'd14, OP_CLR = 8'd15, OP_NOP = 8'd16, OP_DEC = 8'd17,
    OP_INC = 8'd18, OP_HALT = 8'd19
  } opcode_t;

  localparam logic [7:0] OpLast = 8'd19;

  typedef enum logic [3:0] {
    MODE_IMM = 4'd0, MODE_DIR = 4'd1, MODE_IND = 4'd2, MODE_IDX = 4'd3
  } mode_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] load_address;
    logic [31:0] load_data;
  } req_t;

  typedef struct packed {
    logic [15:0] prog_counter;
    logic signed [15:0] index_value;
    logic signed [15:0] accum_value;
    logic        zero_flag;
    logic        neg_flag;
    logic        carry_flag;
    logic        ovf_flag;
    logic        stopped;
    logic [2:0]  fault_code;
    logic        char_valid;
    logic [7:0]  char_out;
  } rsp_t;

  typedef struct packed {
    logic        start;
    logic        is_mod;
    logic signed [15:0] dividend;
    logic signed [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic signed [15:0] quotient;
    logic signed [15:0] remainder;
  } div_rsp_t;

  function automatic logic is_io(input logic [15:0] a);
    return a == AddrDisplay || a == AddrStatus || a == AddrIo2 || a == AddrIo3 ||
           a == AddrKeyb;
  endfunction

endpackage

FILE: hw/rtl/acc_cpu_if.sv
interface acc_cpu_req_if;
  import acc_cpu_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acc_cpu_rsp_if;
  import acc_cpu_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acc_cpu_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/acc_cpu_div.sv
module acc_cpu_div (
  input  logic                  clk,
  input  logic                  rst,
  input  acc_cpu_pkg::div_req_t req,
  output acc_cpu_pkg::div_rsp_t rsp
);
  import acc_cpu_pkg::*;

  logic [15:0] num;
  logic [15:0] den;
  logic [16:0] rem;
  logic [4:0]  count;
  logic        busy;
  logic        neg_q;
  logic        neg_r;
  logic [16:0] trial;

  assign trial = {rem[15:0], num[15]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
      count <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= 5'd16;
        num   <= req.dividend[15] ? 16'(-req.dividend) : req.dividend;
        den   <= req.divisor[15] ? 16'(-req.divisor) : req.divisor;
        neg_q <= req.dividend[15] ^ req.divisor[15];
        neg_r <= req.dividend[15];
        rem   <= '0;
      end else if (busy) begin
        if (count == 5'd0) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quotient  <= neg_q ? 16'(-num) : num;
          rsp.remainder <= neg_r ? 16'(-rem[15:0]) : rem[15:0];
        end else begin
          count <= count - 5'd1;
          if (!trial[16]) begin
            rem <= trial;
            num <= {num[14:0], 1'b1};
          end else begin
            rem <= {rem[15:0], num[15]};
            num <= {num[14:0], 1'b0};
          end
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) rsp.done |-> !busy);
  assert property (@(posedge clk) disable iff (rst) busy |-> count <= 5'd16);
  assert property (@(posedge clk) disable iff (rst) rsp.done |=> !rsp.done);

endmodule

FILE: hw/rtl/accumulator_cpu_core.sv
// Two-register 16-bit accumulator CPU with a private word memory. A load word,
// or a step on a stopped core, goes from idle straight to the result state; a
// step passes through fetch, decode, operand and execute states, with a pointer
// state added for indirect addressing, and skips to the result state when it
// faults at decode. Memory has a registered read port and a write port (fetch,
// up to two operand reads, then a store). DIV and MOD wait on the bit-serial
// divider. The core takes no new word until the current result is taken.
module accumulator_cpu_core #(
  parameter int unsigned MEM_WORDS = acc_cpu_pkg::MemWordsDefault
) (
  input logic         clk,
  input logic         rst,
  acc_cpu_req_if.sink   req,
  acc_cpu_rsp_if.source rsp,
  acc_cpu_cfg_if.sink   cfg
);
  import acc_cpu_pkg::*;

  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DECODE, S_PTR, S_OPND, S_EXEC, S_DIV, S_DONE
  } state_t;

  state_t state;
  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rd_data;
  logic [15:0] rd_addr;
  logic        we;
  logic [AW-1:0] wa;
  logic [31:0] wd;

  logic [15:0] pc_reg, x_reg, acc_reg;
  logic [3:0]  flag_bits;
  logic        halt_state;
  logic [2:0]  fault_reg;
  logic [16:0] protected_limit;
  logic [31:0] ins;
  logic [15:0] ea;
  logic        cv;
  logic [7:0]  ch;
  logic        rd_io;
  logic [15:0] rd_io_val;

  div_req_t dreq;
  div_rsp_t drsp;

  acc_cpu_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[rd_addr[AW-1:0]];
  end

  logic [31:0] bus_val;
  assign bus_val = rd_io ? {16'd0, rd_io_val} : rd_data;

  logic [7:0]  op;
  logic [3:0]  rg, md;
  logic [15:0] opnd;
  assign op   = ins[31:24];
  assign rg   = ins[23:20];
  assign md   = ins[19:16];
  assign opnd = ins[15:0];

  logic signed [15:0] a, val;
  assign a = rg[0] ? acc_reg : x_reg;
  assign val = (md == MODE_IMM) ? opnd : bus_val[15:0];

  logic signed [16:0] sum, dif, inc1, dec1;
  logic signed [31:0] prod;
  assign sum  = 17'(a) + 17'(val);
  assign dif  = 17'(a) - 17'(val);
  assign inc1 = 17'(a) + 17'sd1;
  assign dec1 = 17'(a) - 17'sd1;
  assign prod = a * val;

  always_comb begin
    rd_addr = 16'd0;
    unique case (state)
      S_IDLE:   rd_addr = pc_reg;
      S_DECODE: rd_addr = (md == MODE_IDX) ? 16'(opnd + x_reg) : opnd;
      S_PTR:    rd_addr = bus_val[15:0];
      S_OPND:   rd_addr = ea;
      default:  rd_addr = 16'd0;
    endcase
  end

  assign req.ready = (state == S_IDLE) && !rsp.valid;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc_reg <= '0; x_reg <= '0; acc_reg <= '0; flag_bits <= '0;
      halt_state <= 1'b0; fault_reg <= FAULT_NONE;
      protected_limit <= ProtLimitReset;
      rsp.valid <= 1'b0;
      we <= 1'b0;
      dreq.start <= 1'b0;
      cv <= 1'b0; ch <= 8'd0;
    end else begin
      we <= 1'b0;
      dreq.start <= 1'b0;
      if (cfg.valid) protected_limit <= cfg.data;
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          rd_io <= (pc_reg == AddrStatus) || is_io(pc_reg);
          rd_io_val <= {15'd0, pc_reg == AddrStatus};
          if (req.valid && req.ready) begin
            cv <= 1'b0; ch <= 8'd0;
            if (!req.data.req_type) begin
              we <= 1'b1;
              wa <= req.data.load_address[AW-1:0];
              wd <= req.data.load_data;
              state <= S_DONE;
            end else if (halt_state) begin
              state <= S_DONE;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          ins <= bus_val;
          state <= S_DECODE;
          if (pc_reg == 16'd0 && bus_val == 32'd0) begin
            halt_state <= 1'b1; fault_reg <= FAULT_NULL; state <= S_DONE;
          end else if (bus_val[19:16] > 4'd3) begin
            halt_state <= 1'b1; fault_reg <= FAULT_MODE; state <= S_DONE;
          end else if (bus_val[31:24] > OpLast) begin
            halt_state <= 1'b1; fault_reg <= FAULT_OPCODE; state <= S_DONE;
          end else if (bus_val[23:20] > 4'd1) begin
            halt_state <= 1'b1; fault_reg <= FAULT_REG; state <= S_DONE;
          end
        end
        S_DECODE: begin
          rd_io <= is_io(rd_addr);
          rd_io_val <= {15'd0, rd_addr == AddrStatus};
          ea <= (md == MODE_IMM) ? 16'd0 : rd_addr;
          state <= (md == MODE_IND) ? S_PTR : S_OPND;
        end
        S_PTR: begin
          rd_io <= is_io(rd_addr);
          rd_io_val <= {15'd0, rd_addr == AddrStatus};
          ea <= rd_addr;
          state <= S_OPND;
        end
        S_OPND: state <= S_EXEC;
        S_EXEC: begin
          pc_reg <= pc_reg + 16'd1;
          state <= S_DONE;
          case (op)
            OP_ST: begin
              if (ea == AddrDisplay) begin
                cv <= 1'b1; ch <= a[7:0];
              end else if (!is_io(ea)) begin
                if ({1'b0, ea} < protected_limit) begin
                  halt_state <= 1'b1; fault_reg <= FAULT_PROTECT;
                  pc_reg <= pc_reg;
                end else begin
                  we <= 1'b1; wa <= ea[AW-1:0]; wd <= {{16{a[15]}}, a};
                end
              end
            end
            OP_LD, OP_LDI: begin
              if (rg[0]) acc_reg <= val; else x_reg <= val;
              flag_bits[0] <= val == 0; flag_bits[1] <= val[15];
            end
            OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_CLR: begin
              logic signed [16:0] r;
              logic [15:0] b;
              logic sub;
              r = sum; b = val; sub = 1'b0;
              if (op == OP_SUB) begin r = dif; sub = 1'b1; end
              if (op == OP_INC) begin r = inc1; b = 16'd1; end
              if (op == OP_DEC) begin r = dec1; b = 16'd1; sub = 1'b1; end
              if (op == OP_CLR) begin r = 17'sd0; b = a; sub = 1'b1; end
              if (rg[0]) acc_reg <= r[15:0]; else x_reg <= r[15:0];
              flag_bits[0] <= r == 0;
              flag_bits[1] <= r[16];
              flag_bits[2] <= r[16] != r[15];
              if (!sub)
                flag_bits[3] <= (a > 0 && $signed(b) > 0 && r[15]) ||
                                (a < 0 && $signed(b) < 0 && !r[15] && r[15:0] != 0);
              else
                flag_bits[3] <= (a > 0 && $signed(b) < 0 && r[15]) ||
                                (a < 0 && $signed(b) > 0 && !r[15] && r[15:0] != 0);
            end
            OP_MUL: begin
              if (rg[0]) acc_reg <= prod[15:0]; else x_reg <= prod[15:0];
              flag_bits[0] <= prod == 0; flag_bits[1] <= prod[31];
              flag_bits[2] <= prod != 32'(signed'(prod[15:0]));
              flag_bits[3] <= prod != 32'(signed'(prod[15:0]));
            end
            OP_DIV, OP_MOD: begin
              if (val == 0) begin
                halt_state <= 1'b1; fault_reg <= FAULT_DIVZERO; pc_reg <= pc_reg;
              end else begin
                dreq.start <= 1'b1;
                dreq.dividend <= a; dreq.divisor <= val;
                dreq.is_mod <= op == OP_MOD;
                pc_reg <= pc_reg;
                state <= S_DIV;
              end
            end
            OP_AND, OP_OR, OP_XOR, OP_NOT: begin
              logic [15:0] r;
              r = ~a;
              if (op == OP_AND) r = a & val;
              if (op == OP_OR)  r = a | val;
              if (op == OP_XOR) r = a ^ val;
              if (rg[0]) acc_reg <= r; else x_reg <= r;
              flag_bits[0] <= r == 0; flag_bits[1] <= r[15];
            end
            OP_JMP: pc_reg <= ea;
            OP_JZ: if (flag_bits[0]) pc_reg <= ea;
            OP_JN: if (flag_bits[1]) pc_reg <= ea;
            OP_HALT: halt_state <= 1'b1;
            default: ;
          endcase
        end
        S_DIV: begin
          if (drsp.done) begin
            logic [15:0] r;
            logic        neg;
            r = dreq.is_mod ? drsp.remainder : drsp.quotient;
            // a quotient of +32768 wraps but stays positive
            neg = dreq.is_mod ? r[15] :
                  ((dreq.dividend[15] ^ dreq.divisor[15]) && r != 16'd0);
            if (rg[0]) acc_reg <= r; else x_reg <= r;
            flag_bits <= {2'b00, neg, r == 16'd0};
            pc_reg <= pc_reg + 16'd1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          rsp.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.data.prog_counter = pc_reg;
    rsp.data.index_value  = x_reg;
    rsp.data.accum_value  = acc_reg;
    rsp.data.zero_flag    = flag_bits[0];
    rsp.data.neg_flag     = flag_bits[1];
    rsp.data.carry_flag   = flag_bits[2];
    rsp.data.ovf_flag     = flag_bits[3];
    rsp.data.stopped      = halt_state;
    rsp.data.fault_code   = fault_reg;
    rsp.data.char_valid   = cv;
    rsp.data.char_out     = ch;
  end

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> state == S_IDLE) else $error("result shown mid-instruction");
  assert property (@(posedge clk) disable iff (rst)
    fault_reg != FAULT_NONE |-> halt_state) else $error("fault without stop");
  assert property (@(posedge clk) disable iff (rst)
    !rsp.data.char_valid |-> rsp.data.char_out == 8'd0) else $error("stray char");
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state != S_IDLE) else $error("item dropped");

endmodule

FILE: tb/sv/accumulator_cpu_core_test.sv
module accumulator_cpu_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import acc_cpu_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int PhaseWords = 300;

  typedef struct {
    logic [15:0] pc;
    logic [15:0] x;
    logic [15:0] acc;
    bit          z;
    bit          n;
    bit          c;
    bit          v;
    bit          halted;
    fault_t      flt;
  } cpu_t;

  typedef struct {
    bit          is_step;
    logic [15:0] addr;
    logic [31:0] word;
    bit          typed;
    rsp_t        want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  acc_cpu_req_if req_ch ();
  acc_cpu_rsp_if rsp_ch ();
  acc_cpu_cfg_if cfg_ch ();

  accumulator_cpu_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  logic [31:0] mem_img [int unsigned];
  cpu_t        cpu;
  logic [16:0] prot_limit;
  rsp_t        pending_state [$];
  bit          quiet;
  int          errors;
  int          words_sent;
  int          idle_cycles;
  dir_row_t    dir_rows [25];

  always #6 clk = ~clk;

  function automatic bit io_addr(logic [15:0] a);
    return a == AddrDisplay || a == AddrStatus || a == AddrIo2 || a == AddrIo3 ||
           a == AddrKeyb;
  endfunction

  function automatic int sx(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic bit wide(int r);
    return r > 32767 || r < -32768;
  endfunction

  function automatic logic [31:0] bus_rd(logic [15:0] a, inout bit miss);
    if (a == AddrStatus) return 32'd1;
    if (io_addr(a)) return 32'd0;
    if (!mem_img.exists(a)) begin
      miss = 1'b1;
      return 32'd0;
    end
    return mem_img[a];
  endfunction

  function automatic void set_zn(inout cpu_t s, input int r);
    s.z = (r == 0);
    s.n = (r < 0);
  endfunction

  function automatic int add_flags(inout cpu_t s, input int a, input int b);
    int r;
    int w;
    r = a + b;
    w = sx(16'(r));
    s.c = wide(r);
    s.v = (a > 0 && b > 0 && w < 0) || (a < 0 && b < 0 && w > 0);
    set_zn(s, r);
    return r;
  endfunction

  function automatic int sub_flags(inout cpu_t s, input int a, input int b);
    int r;
    int w;
    r = a - b;
    w = sx(16'(r));
    s.c = wide(r);
    s.v = (a > 0 && b < 0 && w < 0) || (a < 0 && b > 0 && w > 0);
    set_zn(s, r);
    return r;
  endfunction

  function automatic rsp_t snap(cpu_t s, bit cv, logic [7:0] ch);
    rsp_t o;
    o.prog_counter = s.pc;
    o.index_value  = s.x;
    o.accum_value  = s.acc;
    o.zero_flag    = s.z;
    o.neg_flag     = s.n;
    o.carry_flag   = s.c;
    o.ovf_flag     = s.v;
    o.stopped      = s.halted;
    o.fault_code   = s.flt;
    o.char_valid   = cv;
    o.char_out     = cv ? ch : 8'd0;
    return o;
  endfunction

  function automatic void cpu_exec(inout cpu_t s, input bit commit, output rsp_t o,
                                   output bit miss);
    logic [31:0] ins;
    opcode_t     op;
    logic [3:0]  rg;
    logic [3:0]  md;
    logic [15:0] opnd;
    logic [15:0] ea;
    logic [15:0] npc;
    int          val;
    int          a;
    int          r;
    bit          wr;
    bit          cv;
    logic [7:0]  ch;
    fault_t      f;
    miss = 1'b0;
    cv = 1'b0;
    ch = 8'd0;
    wr = 1'b0;
    f = FAULT_NONE;
    if (!s.halted) begin
      ins = bus_rd(s.pc, miss);
      rg = ins[23:20];
      md = ins[19:16];
      opnd = ins[15:0];
      if (s.pc == 16'd0 && ins == 32'd0) f = FAULT_NULL;
      else if (md > 4'd3) f = FAULT_MODE;
      else if (ins[31:24] > OpLast) f = FAULT_OPCODE;
      else if (rg > 4'd1) f = FAULT_REG;
      else begin
        op = opcode_t'(ins[31:24]);
        ea = 16'd0;
        if (md == MODE_IMM) val = sx(opnd);
        else begin
          if (md == MODE_DIR) ea = opnd;
          else if (md == MODE_IND) ea = 16'(bus_rd(opnd, miss));
          else ea = opnd + s.x;
          val = sx(16'(bus_rd(ea, miss)));
        end
        a = sx(rg[0] ? s.acc : s.x);
        npc = s.pc + 16'd1;
        r = a;
        case (op)
          OP_ST: begin
            if (ea == AddrDisplay) begin
              cv = 1'b1;
              ch = 8'(a);
            end else if (!io_addr(ea)) begin
              if ({1'b0, ea} < prot_limit) f = FAULT_PROTECT;
              else if (commit) mem_img[ea] = 32'(a);
            end
          end
          OP_LD, OP_LDI: begin
            r = val;
            set_zn(s, r);
            wr = 1'b1;
          end
          OP_ADD: begin r = add_flags(s, a, val); wr = 1'b1; end
          OP_SUB: begin r = sub_flags(s, a, val); wr = 1'b1; end
          OP_MUL: begin
            r = a * val;
            s.c = wide(r);
            s.v = s.c;
            set_zn(s, r);
            wr = 1'b1;
          end
          OP_DIV, OP_MOD: begin
            if (val == 0) f = FAULT_DIVZERO;
            else begin
              r = (op == OP_DIV) ? a / val : a % val;
              s.c = 1'b0;
              s.v = 1'b0;
              set_zn(s, r);
              wr = 1'b1;
            end
          end
          OP_AND: begin r = a & val; set_zn(s, r); wr = 1'b1; end
          OP_OR:  begin r = a | val; set_zn(s, r); wr = 1'b1; end
          OP_XOR: begin r = a ^ val; set_zn(s, r); wr = 1'b1; end
          OP_NOT: begin r = ~a; set_zn(s, r); wr = 1'b1; end
          OP_JMP: npc = ea;
          OP_JZ:  if (s.z) npc = ea;
          OP_JN:  if (s.n) npc = ea;
          OP_CLR: begin r = sub_flags(s, a, a); wr = 1'b1; end
          OP_NOP: ;
          OP_DEC: begin r = sub_flags(s, a, 1); wr = 1'b1; end
          OP_INC: begin r = add_flags(s, a, 1); wr = 1'b1; end
          default: s.halted = 1'b1;
        endcase
        if (f == FAULT_NONE) begin
          if (wr && rg[0]) s.acc = 16'(r);
          else if (wr) s.x = 16'(r);
          s.pc = npc;
        end
      end
      if (f != FAULT_NONE) begin
        s.halted = 1'b1;
        s.flt = f;
        cv = 1'b0;
      end
    end
    o = snap(s, cv, ch);
  endfunction

  function automatic rsp_t predict_state(req_t w);
    rsp_t o;
    bit   miss;
    if (!w.req_type) begin
      mem_img[w.load_address] = w.load_data;
      o = snap(cpu, 1'b0, 8'd0);
    end else cpu_exec(cpu, 1'b1, o, miss);
    return o;
  endfunction

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'h0000_7FFF;
      3: return 32'hFFFF_8000;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_addr();
    int l;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1023));
      2: return 16'($urandom_range(16'hFFE0, 16'hFFFF));
      default: begin
        l = int'(prot_limit) + $urandom_range(0, 4) - 2;
        if (l < 0) l = 0;
        if (l > 65535) l = 65535;
        return 16'(l);
      end
    endcase
  endfunction

  task automatic send_word(input req_t w, input bit typed, input rsp_t want);
    rsp_t p;
    while (!quiet && $urandom_range(0, 99) < 25) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.data = w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    p = predict_state(w);
    pending_state.push_back(typed ? want : p);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic load_word(input logic [15:0] a, input logic [31:0] d);
    req_t w;
    w.req_type = 1'b0;
    w.load_address = a;
    w.load_data = d;
    send_word(w, 1'b0, '0);
  endtask

  task automatic step_once();
    req_t w;
    w.req_type = 1'b1;
    w.load_address = 16'($urandom);
    w.load_data = $urandom;
    send_word(w, 1'b0, '0);
  endtask

  task automatic write_limit(input logic [16:0] v);
    req_ch.valid = 1'b0;
    while (pending_state.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    prot_limit = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Build one well-formed instruction at pc, its pointer and data words, then step.
  task automatic run_instruction();
    opcode_t     op;
    mode_t       md;
    logic [3:0]  rg;
    logic [15:0] opnd;
    logic [15:0] ea;
    cpu_t        trial;
    rsp_t        o;
    bit          miss;
    op = opcode_t'($urandom_range(0, 18));
    md = mode_t'($urandom_range(0, 3));
    rg = 4'($urandom_range(0, 1));
    opnd = pick_addr();
    if ($urandom_range(0, 9) == 0) load_word(16'($urandom), $urandom);
    if (md == MODE_IMM && $urandom_range(0, 1)) opnd = 16'(pick_val());
    ea = opnd;
    if (md == MODE_IND) begin
      if (!io_addr(opnd) && (!mem_img.exists(opnd) || $urandom_range(0, 3) != 0))
        load_word(opnd, {16'($urandom), pick_addr()});
      ea = 16'(bus_rd(opnd, miss));
    end else if (md == MODE_IDX) ea = opnd + cpu.x;
    if (md != MODE_IMM && !io_addr(ea) && (!mem_img.exists(ea) || $urandom_range(0, 1)))
      load_word(ea, pick_val());
    load_word(cpu.pc, {op, rg, md, opnd});
    trial = cpu;
    cpu_exec(trial, 1'b0, o, miss);
    if (miss || trial.halted || io_addr(trial.pc))
      load_word(cpu.pc, {OP_JMP, 4'($urandom_range(0, 1)), MODE_IMM, 16'($urandom)});
    step_once();
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    rsp_ch.ready = quiet || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (pending_state.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %0h", $time, got);
      end else begin
        want = pending_state.pop_front();
        check_field("prog_counter", want.prog_counter, got.prog_counter);
        check_field("index_value", want.index_value, got.index_value);
        check_field("accum_value", want.accum_value, got.accum_value);
        check_field("zero_flag", want.zero_flag, got.zero_flag);
        check_field("neg_flag", want.neg_flag, got.neg_flag);
        check_field("carry_flag", want.carry_flag, got.carry_flag);
        check_field("ovf_flag", want.ovf_flag, got.ovf_flag);
        check_field("stopped", want.stopped, got.stopped);
        check_field("fault_code", want.fault_code, got.fault_code);
        check_field("char_valid", want.char_valid, got.char_valid);
        check_field("char_out", want.char_out, got.char_out);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [16:0] limits [6];
    rsp_t        after_ldi;
    req_t        w;
    int          phase_end;
    int          kind;
    logic [31:0] bad;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    quiet = 1'b0;
    errors = 0;
    words_sent = 0;
    idle_cycles = 0;
    cpu = '{default: '0, flt: FAULT_NONE};
    prot_limit = ProtLimitReset;

    after_ldi = '0;
    after_ldi.prog_counter = 16'd1;
    after_ldi.accum_value = 16'sh7FFF;
    dir_rows[0]  = '{1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, rsp_t'('0)};
    dir_rows[1]  = '{1'b0, 16'h0000, 32'h0210_7FFF, 1'b1, rsp_t'('0)};
    dir_rows[2]  = '{1'b1, 16'h0000, 32'h0000_0000, 1'b1, after_ldi};
    dir_rows[3]  = '{1'b0, 16'h0001, 32'h0310_0001, 1'b0, rsp_t'('0)};
    dir_rows[4]  = '{1'b1, 16'hA5A5, 32'h5A5A_5A5A, 1'b0, rsp_t'('0)};
    dir_rows[5]  = '{1'b0, 16'h0300, 32'h0000_7FFF, 1'b0, rsp_t'('0)};
    dir_rows[6]  = '{1'b0, 16'h0002, 32'h0411_0300, 1'b0, rsp_t'('0)};
    dir_rows[7]  = '{1'b1, 16'h5A5A, 32'hA5A5_A5A5, 1'b0, rsp_t'('0)};
    dir_rows[8]  = '{1'b0, 16'h0301, 32'h0000_0302, 1'b0, rsp_t'('0)};
    dir_rows[9]  = '{1'b0, 16'h0302, 32'hFFFF_8000, 1'b0, rsp_t'('0)};
    dir_rows[10] = '{1'b0, 16'h0003, 32'h0202_0301, 1'b0, rsp_t'('0)};
    dir_rows[11] = '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, rsp_t'('0)};
    dir_rows[12] = '{1'b0, 16'h0004, 32'h0600_FFFF, 1'b0, rsp_t'('0)};
    dir_rows[13] = '{1'b1, 16'h0000, 32'h0000_0000, 1'b0, rsp_t'('0)};
    dir_rows[14] = '{1'b0, 16'h8000, 32'h0000_0007, 1'b0, rsp_t'('0)};
    dir_rows[15] = '{1'b0, 16'h0005, 32'h0713_0000, 1'b0, rsp_t'('0)};
    dir_rows[16] = '{1'b1, 16'h1234, 32'h89AB_CDEF, 1'b0, rsp_t'('0)};
    dir_rows[17] = '{1'b0, 16'h0006, 32'h0011_FFF0, 1'b0, rsp_t'('0)};
    dir_rows[18] = '{1'b1, 16'hEDCB, 32'h7654_3210, 1'b0, rsp_t'('0)};
    dir_rows[19] = '{1'b0, 16'h0007, 32'h0B10_0000, 1'b0, rsp_t'('0)};
    dir_rows[20] = '{1'b1, 16'h0F0F, 32'hF0F0_F0F0, 1'b0, rsp_t'('0)};
    dir_rows[21] = '{1'b0, 16'h0008, 32'h0111_FFF1, 1'b0, rsp_t'('0)};
    dir_rows[22] = '{1'b1, 16'hF0F0, 32'h0F0F_0F0F, 1'b0, rsp_t'('0)};
    dir_rows[23] = '{1'b0, 16'h0009, 32'h0C00_0000, 1'b0, rsp_t'('0)};
    dir_rows[24] = '{1'b1, 16'h8001, 32'h1357_9BDF, 1'b0, rsp_t'('0)};

    repeat (7) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      w.req_type = dir_rows[i].is_step;
      w.load_address = dir_rows[i].addr;
      w.load_data = dir_rows[i].word;
      send_word(w, dir_rows[i].typed, dir_rows[i].want);
    end

    limits[0] = 17'd0;
    limits[1] = 17'd65536;
    limits[2] = 17'd1;
    limits[3] = 17'd65535;
    limits[4] = 17'($urandom_range(0, 65536));
    limits[5] = ProtLimitReset;
    foreach (limits[p]) begin
      write_limit(limits[p]);
      quiet = (p == 2);
      phase_end = words_sent + PhaseWords;
      while (words_sent < phase_end) run_instruction();
      quiet = 1'b0;
    end

    // End with the one stopping event, then poke the stopped core.
    kind = $urandom_range(0, 6);
    bad = {8'($urandom_range(0, 19)), 4'($urandom_range(0, 1)), MODE_IMM, 16'($urandom)};
    case (kind)
      0: bad = {OP_HALT, 4'($urandom_range(0, 15)), MODE_IMM, 16'($urandom)};
      1: bad = {8'($urandom_range(20, 255)), 4'($urandom), 4'($urandom_range(0, 3)),
                16'($urandom)};
      2: bad = {8'($urandom), 4'($urandom), 4'($urandom_range(4, 15)), 16'($urandom)};
      3: bad = {8'($urandom_range(0, 19)), 4'($urandom_range(2, 15)),
                4'($urandom_range(0, 3)), 16'($urandom)};
      4: bad = {($urandom_range(0, 1) ? OP_DIV : OP_MOD), 4'($urandom_range(0, 1)),
                MODE_IMM, 16'd0};
      5: bad = {OP_ST, 4'($urandom_range(0, 1)), MODE_DIR,
                16'($urandom_range(0, int'(prot_limit) - 1))};
      default: begin
        load_word(cpu.pc, {OP_JMP, 4'd0, MODE_IMM, 16'($urandom)});
        step_once();
        bad = 32'd0;
      end
    endcase
    load_word(cpu.pc, bad);
    step_once();
    repeat (3) begin
      step_once();
      load_word(16'($urandom), $urandom);
    end
    req_ch.valid = 1'b0;

    while (pending_state.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/acc_cpu_pkg.sv
hw/rtl/acc_cpu_if.sv
hw/rtl/acc_cpu_div.sv
hw/rtl/accumulator_cpu_core.sv
tb/sv/accumulator_cpu_core_test.sv
